>>> rtl/svice_pkg.sv
// shared types, constants and helpers for the raw svi smile evaluator
// no dependencies; imported by the cells and by svi_curve_evaluate_core

package svice_pkg;

  localparam int FRAC_BITS = 20;

  // register map, word index on the config port
  localparam logic [2:0] REG_LEVEL_A = 3'd0;
  localparam logic [2:0] REG_SLOPE_B = 3'd1;
  localparam logic [2:0] REG_SKEW_RHO = 3'd2;
  localparam logic [2:0] REG_SHIFT_M = 3'd3;
  localparam logic [2:0] REG_SIGMA = 3'd4;

  // square root: radicand below 2^50, 25 result bits, one bit pair per cell
  localparam int SQ_W = 50;
  localparam int SQ_STEPS = 25;

  // restoring divide: remainder and shifted divisor share one width
  localparam int DIV_W = 106;
  localparam int DIV_STEPS = 31;
  localparam int QUO_W = 32;

  typedef struct packed {
    logic [SQ_W-1:0] v;
    logic [SQ_W-1:0] r;
    logic [SQ_W-1:0] one;
  } sq_cell_t;

  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [DIV_W-1:0] dsh;
    logic [QUO_W-1:0] quo;
  } div_cell_t;

  typedef struct packed {
    logic [31:0] val;
    logic        sat;
  } clip_t;

  // clamp a sign and magnitude value into signed 32 bits
  function automatic clip_t clip32(input logic neg, input logic [63:0] mag);
    clip_t res;
    res.sat = 1'b0;
    if (neg) begin
      if (mag > 64'h8000_0000) begin
        res.val = 32'h8000_0000;
        res.sat = 1'b1;
      end else begin
        res.val = 32'(64'd0 - mag);
      end
    end else begin
      if (mag > 64'h7FFF_FFFF) begin
        res.val = 32'h7FFF_FFFF;
        res.sat = 1'b1;
      end else begin
        res.val = mag[31:0];
      end
    end
    return res;
  endfunction

endpackage

>>> rtl/svi_curve_evaluate_core.sv
// raw svi smile evaluator: total variance, slope, curvature per strike
// depends on svice_pkg, svice_sqrt_cell and svice_div_cell
//
// usage
//   input channel: in_valid/in_ready carry one signed q4.20 log-moneyness
//   per transfer. output channel: out_valid/out_ready carry total variance,
//   slope and curvature (signed q12.20, clamped), a convexity flag and a
//   flag that any value was clamped.
//   config: apb-style write/read of a, b, rho, m, sigma at 4*index; write
//   only while no strike is in flight.
//   throughput: one strike per cycle unless the output stalls; every stage
//   is a register and the root and the two divisions are rows of one-step
//   cells. stages: 3 entry stages, 25 square root cells, 4 product stages,
//   31 divide cells, a final stage and the output register.
//   reset: rst_n low clears all valid bits and loads the register defaults;
//   no clearing pass is needed.
//   stall: while a result waits in the output register the whole row holds,
//   in_ready included; bubbles inside the row do not close up.

module svi_curve_evaluate_core import svice_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // config port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // strike stream
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [23:0] in_strike_offset,
  // result stream
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_total_variance,
  output logic signed [31:0] out_slope,
  output logic signed [31:0] out_curvature,
  output logic               out_convex_flag,
  output logic               out_saturated
);

  // stage map: 0..2 entry, sqrt cells, four product stages, divide cells, final
  localparam int SQ_BASE  = 3;
  localparam int P4_STAGE = SQ_BASE + SQ_STEPS + 3;
  localparam int NST      = P4_STAGE + DIV_STEPS + 2;

  typedef struct packed {
    logic signed [24:0] d;
    logic        [24:0] dm;
  } sq_side_t;

  typedef struct packed {
    logic [31:0] tv;
    logic        tv_sat;
    logic        ovf;
    logic        szero;
    logic        dneg;
  } div_side_t;

  // ---------------- configuration registers ----------------
  logic        [22:0] level_a_r;
  logic        [22:0] slope_b_r;
  logic signed [20:0] skew_rho_r;
  logic signed [23:0] shift_m_r;
  logic        [22:0] sigma_r;
  logic               cfg_wr;
  logic [2:0]         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_a_r  <= 23'd0;
      slope_b_r  <= 23'd105;
      skew_rho_r <= 21'sd0;
      shift_m_r  <= 24'sd0;
      sigma_r    <= 23'd1048576;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_LEVEL_A:  level_a_r  <= pwdata[22:0];
        REG_SLOPE_B:  slope_b_r  <= pwdata[22:0];
        REG_SKEW_RHO: skew_rho_r <= pwdata[20:0];
        REG_SHIFT_M:  shift_m_r  <= pwdata[23:0];
        REG_SIGMA:    sigma_r    <= pwdata[22:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_LEVEL_A:  prdata = {9'd0, level_a_r};
      REG_SLOPE_B:  prdata = {9'd0, slope_b_r};
      REG_SKEW_RHO: prdata = {{11{skew_rho_r[20]}}, skew_rho_r};
      REG_SHIFT_M:  prdata = {{8{shift_m_r[23]}}, shift_m_r};
      REG_SIGMA:    prdata = {9'd0, sigma_r};
      default:      prdata = 32'd0;
    endcase
  end

  // sigma^2 and b*sigma^2 follow the registers through sg2_r, the two b*sigma^2
  // halves and bsg2_r; a strike needs them much deeper in the row
  logic [45:0] sg2_r;
  logic [45:0] bsg_lo_r;
  logic [45:0] bsg_hi_r;
  logic [68:0] bsg2_r;

  always_ff @(posedge clk) begin
    sg2_r    <= sigma_r * sigma_r;
    bsg_lo_r <= slope_b_r * sg2_r[22:0];
    bsg_hi_r <= slope_b_r * sg2_r[45:23];
    bsg2_r   <= {23'd0, bsg_lo_r} + {bsg_hi_r, 23'd0};
  end

  // ---------------- flow control ----------------
  logic [NST-1:0] vld_r;
  logic           out_valid_r;
  logic           adv;

  assign adv       = out_ready | ~out_valid_r;
  assign in_ready  = adv;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[NST-2:0], in_valid};
      out_valid_r <= vld_r[NST-1];
    end
  end

  // ---------------- entry stages ----------------
  logic signed [23:0] k_r;
  logic signed [24:0] d_r;
  logic signed [24:0] d2_r;
  logic        [24:0] dmag_r;
  logic        [49:0] dsq_r;
  logic        [24:0] dmag_nxt;

  assign dmag_nxt = d_r[24] ? 25'(-d_r) : 25'(d_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      k_r    <= in_strike_offset;
      d_r    <= {k_r[23], k_r} - {shift_m_r[23], shift_m_r};
      d2_r   <= d_r;
      dmag_r <= dmag_nxt;
      dsq_r  <= dmag_nxt * dmag_nxt;
    end
  end

  // ---------------- square root row ----------------
  sq_cell_t sq_link [SQ_STEPS+1];
  sq_side_t sq_side_r [SQ_STEPS];

  assign sq_link[0] = '{v: dsq_r + {4'd0, sg2_r}, r: '0,
                        one: SQ_W'(1) << (SQ_W - 2)};

  for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sq
    svice_sqrt_cell u_cell (
      .clk      (clk),
      .en       (adv),
      .cell_in  (sq_link[g]),
      .cell_out (sq_link[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_side_r[0] <= '{d: d2_r, dm: dmag_r};
      for (int i = 1; i < SQ_STEPS; i++) begin
        sq_side_r[i] <= sq_side_r[i-1];
      end
    end
  end

  // ---------------- product stages ----------------
  logic        [24:0] s_root;
  logic        [24:0] p1_s_r, p2_s_r, p3_s_r, p4_s_r;
  logic        [24:0] p1_dm_r, p2_dm_r, p3_dm_r, p4_dm_r;
  logic               p1_dneg_r, p2_dneg_r, p3_dneg_r, p4_dneg_r;
  logic signed [45:0] p1_rhod_r;
  logic        [49:0] p1_ss_r;
  logic signed [46:0] p2_inner_r;
  logic        [49:0] p2_s3lo_r;
  logic        [49:0] p2_s3hi_r;
  logic        [45:0] p3_bl_r;
  logic        [45:0] p3_bh_r;
  logic               p3_neg_r;
  logic        [74:0] p3_den_r;
  logic        [74:0] p4_den_r;
  logic        [31:0] p4_tv_r;
  logic               p4_tvsat_r;
  logic               p4_szero_r;
  logic        [45:0] inner_mag;
  logic        [68:0] tv_prod;
  logic        [28:0] tv_term;
  logic        [29:0] tv_mag;
  logic               tv_neg;
  clip_t              tv_clip;

  assign s_root    = sq_link[SQ_STEPS].r[24:0];
  assign inner_mag = p2_inner_r[46] ? 46'(-p2_inner_r) : 46'(p2_inner_r);

  // total variance: (b*|inner|) >> 2F, then a added with the sign of inner
  always_comb begin
    tv_prod = {23'd0, p3_bl_r} + {p3_bh_r, 23'd0};
    tv_term = tv_prod[68:2*FRAC_BITS];
    tv_neg  = 1'b0;
    if (p3_neg_r) begin
      if ({1'b0, tv_term} <= {7'd0, level_a_r}) begin
        tv_mag = {7'd0, level_a_r} - {1'b0, tv_term};
      end else begin
        tv_mag = {1'b0, tv_term} - {7'd0, level_a_r};
        tv_neg = 1'b1;
      end
    end else begin
      tv_mag = {1'b0, tv_term} + {7'd0, level_a_r};
    end
    tv_clip = clip32(tv_neg, {34'd0, tv_mag});
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // rho*d and s*s
      p1_s_r    <= s_root;
      p1_dm_r   <= sq_side_r[SQ_STEPS-1].dm;
      p1_dneg_r <= sq_side_r[SQ_STEPS-1].d[24];
      p1_rhod_r <= skew_rho_r * sq_side_r[SQ_STEPS-1].d;
      p1_ss_r   <= s_root * s_root;
      // inner term and the two halves of s^3
      p2_s_r     <= p1_s_r;
      p2_dm_r    <= p1_dm_r;
      p2_dneg_r  <= p1_dneg_r;
      p2_inner_r <= {p1_rhod_r[45], p1_rhod_r} +
                    $signed({2'b00, p1_s_r, {FRAC_BITS{1'b0}}});
      p2_s3lo_r  <= p1_ss_r[24:0] * p1_s_r;
      p2_s3hi_r  <= p1_ss_r[49:25] * p1_s_r;
      // b*|inner| in two halves, s^3 assembled
      p3_s_r    <= p2_s_r;
      p3_dm_r   <= p2_dm_r;
      p3_dneg_r <= p2_dneg_r;
      p3_neg_r  <= p2_inner_r[46];
      p3_bl_r   <= slope_b_r * inner_mag[22:0];
      p3_bh_r   <= slope_b_r * inner_mag[45:23];
      p3_den_r  <= {25'd0, p2_s3lo_r} + {p2_s3hi_r, 25'd0};
      // total variance done, divisions set up
      p4_s_r     <= p3_s_r;
      p4_dm_r    <= p3_dm_r;
      p4_dneg_r  <= p3_dneg_r;
      p4_den_r   <= p3_den_r;
      p4_szero_r <= (p3_s_r == 25'd0);
      p4_tv_r    <= tv_clip.val;
      p4_tvsat_r <= tv_clip.sat;
    end
  end

  // ---------------- divide rows ----------------
  // curvature: b*sigma^2*2^F / s^3; slope quotient: |d|*2^F / s
  div_cell_t   cv_link [DIV_STEPS+1];
  div_cell_t   sl_link [DIV_STEPS+1];
  div_side_t   div_side_r [DIV_STEPS];
  logic [DIV_W-1:0] cv_num;
  logic             cv_ovf;

  assign cv_num = DIV_W'({bsg2_r, {FRAC_BITS{1'b0}}});
  // quotient of 2^31 or more clamps; tested once here
  assign cv_ovf = cv_num >= DIV_W'({p4_den_r, {DIV_STEPS{1'b0}}});
  assign cv_link[0] = '{rem: cv_num,
                        dsh: DIV_W'({p4_den_r, {(DIV_STEPS-1){1'b0}}}),
                        quo: '0};
  assign sl_link[0] = '{rem: DIV_W'({p4_dm_r, {FRAC_BITS{1'b0}}}),
                        dsh: DIV_W'({p4_s_r, {(DIV_STEPS-1){1'b0}}}),
                        quo: '0};

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    svice_div_cell u_cv_cell (
      .clk      (clk),
      .en       (adv),
      .cell_in  (cv_link[g]),
      .cell_out (cv_link[g+1])
    );
    svice_div_cell u_sl_cell (
      .clk      (clk),
      .en       (adv),
      .cell_in  (sl_link[g]),
      .cell_out (sl_link[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      div_side_r[0] <= '{tv: p4_tv_r, tv_sat: p4_tvsat_r,
                         ovf: cv_ovf & ~p4_szero_r, szero: p4_szero_r,
                         dneg: p4_dneg_r};
      for (int i = 1; i < DIV_STEPS; i++) begin
        div_side_r[i] <= div_side_r[i-1];
      end
    end
  end

  // ---------------- final stage ----------------
  div_side_t          side_end;
  logic        [21:0] sl_q;
  logic signed [23:0] sl_qs;
  logic signed [23:0] sl_p;
  logic        [23:0] sl_pmag;
  logic        [46:0] f1_prod_r;
  logic               f1_pneg_r;
  logic        [31:0] f1_cv_r;
  logic               f1_cvsat_r;
  logic        [31:0] f1_tv_r;
  logic               f1_tvsat_r;
  logic        [31:0] cv_val;
  logic               cv_sat;
  clip_t              sl_clip;

  assign side_end = div_side_r[DIV_STEPS-1];

  always_comb begin
    // zero root: quotients taken as zero
    sl_q    = side_end.szero ? 22'd0 : sl_link[DIV_STEPS].quo[21:0];
    sl_qs   = side_end.dneg ? -$signed({2'b00, sl_q}) : $signed({2'b00, sl_q});
    sl_p    = {{3{skew_rho_r[20]}}, skew_rho_r} + sl_qs;
    sl_pmag = sl_p[23] ? 24'(-sl_p) : 24'(sl_p);
    cv_sat  = 1'b0;
    if (side_end.szero) begin
      cv_val = 32'd0;
    end else if (side_end.ovf) begin
      cv_val = 32'h7FFF_FFFF;
      cv_sat = 1'b1;
    end else begin
      cv_val = {1'b0, cv_link[DIV_STEPS].quo[30:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_prod_r  <= slope_b_r * sl_pmag;
      f1_pneg_r  <= sl_p[23];
      f1_cv_r    <= cv_val;
      f1_cvsat_r <= cv_sat;
      f1_tv_r    <= side_end.tv;
      f1_tvsat_r <= side_end.tv_sat;
    end
  end

  assign sl_clip = clip32(f1_pneg_r, 64'(f1_prod_r >> FRAC_BITS));

  // output register
  always_ff @(posedge clk) begin
    if (adv) begin
      out_total_variance <= f1_tv_r;
      out_slope          <= sl_clip.val;
      out_curvature      <= f1_cv_r;
      out_convex_flag    <= ~f1_cv_r[31];
      out_saturated      <= f1_tvsat_r | f1_cvsat_r | sl_clip.sat;
    end
  end

  // ---------------- assertions ----------------
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  a_curv_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_convex_flag && !out_curvature[31])
    else $error("negative curvature delivered");

  a_hold_full: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NST-1] && out_valid && !out_ready |=> vld_r[NST-1] && out_valid)
    else $error("result dropped under stall");

endmodule

>>> rtl/svice_sqrt_cell.sv
// one bit-pair step of the floored integer square root
// depends on svice_pkg for the cell struct

module svice_sqrt_cell import svice_pkg::*; (
  input  logic     clk,
  input  logic     en,
  input  sq_cell_t cell_in,
  output sq_cell_t cell_out
);

  logic [SQ_W-1:0] trial;
  sq_cell_t        cell_nxt;

  always_comb begin
    trial = cell_in.r + cell_in.one;
    cell_nxt.one = cell_in.one >> 2;
    if (cell_in.v >= trial) begin
      cell_nxt.v = cell_in.v - trial;
      cell_nxt.r = (cell_in.r >> 1) + cell_in.one;
    end else begin
      cell_nxt.v = cell_in.v;
      cell_nxt.r = cell_in.r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_out <= cell_nxt;
    end
  end

endmodule

>>> rtl/svice_div_cell.sv
// one restoring step of unsigned division, divisor shifted right per cell
// depends on svice_pkg for the cell struct

module svice_div_cell import svice_pkg::*; (
  input  logic      clk,
  input  logic      en,
  input  div_cell_t cell_in,
  output div_cell_t cell_out
);

  logic      fits;
  div_cell_t cell_nxt;

  always_comb begin
    fits = cell_in.rem >= cell_in.dsh;
    cell_nxt.rem = fits ? (cell_in.rem - cell_in.dsh) : cell_in.rem;
    cell_nxt.dsh = cell_in.dsh >> 1;
    cell_nxt.quo = {cell_in.quo[QUO_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_out <= cell_nxt;
    end
  end

endmodule

>>> bench/tb_svi_curve_evaluate_core.sv
// self-checking bench for svi_curve_evaluate_core: directed cases, then random strikes
// depends on svice_pkg and the core; predictor computes the smile in wide integer math
`timescale 1ns / 1ps

module tb_svi_curve_evaluate_core import svice_pkg::*; ();

  localparam int CORE_LATENCY = 64;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_STRIKES = 1850;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [4:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;
  logic in_valid, in_ready;
  logic signed [23:0] in_strike_offset;
  logic out_valid, out_ready;
  logic signed [31:0] out_total_variance, out_slope, out_curvature;
  logic out_convex_flag, out_saturated;

  svi_curve_evaluate_core dut (.*);

  // one evaluated smile point
  typedef struct {
    logic [31:0] tv;
    logic [31:0] sl;
    logic [31:0] cv;
    logic        convex;
    logic        sat;
  } smile_point_t;

  // predictor's copy of the parameter registers
  logic [22:0] p_a, p_b, p_sigma;
  logic [20:0] p_rho;
  logic [23:0] p_m;

  smile_point_t pending_points[$];
  int mismatches;
  int strikes_sent;
  int points_checked;
  int idle_cycles;
  int long_gap_pct;

  // sign and magnitude clamp into signed 32 bits
  function automatic logic [31:0] clamp_sm(input logic neg, input logic [127:0] mag,
                                           inout logic sat);
    if (neg) begin
      if (mag > 128'h8000_0000) begin
        sat = 1'b1;
        return 32'h8000_0000;
      end
      return 32'(128'd0 - mag);
    end
    if (mag > 128'h7FFF_FFFF) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    return mag[31:0];
  endfunction

  function automatic logic [63:0] floor_root(input logic [63:0] v);
    logic [63:0] r, bitv, x;
    r = 0;
    x = v;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x = x - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  function automatic smile_point_t evaluate_smile(input logic [23:0] strike);
    smile_point_t pt;
    logic signed [63:0] k, m, rho, d, inner, p, q;
    logic [63:0] dm, sg2, s, im, pm, qm;
    logic [127:0] term, r, prod, num, den, quo;
    logic neg, sat;
    sat = 1'b0;
    k = 64'(signed'(strike));
    m = 64'(signed'(p_m));
    rho = 64'(signed'(p_rho));
    d = k - m;
    dm = d < 0 ? -d : d;
    sg2 = 64'(p_sigma) * 64'(p_sigma);
    s = floor_root(dm * dm + sg2);
    // total variance: exact product, truncated, then level added
    inner = rho * d + signed'(s << FRAC_BITS);
    im = inner < 0 ? -inner : inner;
    term = (128'(p_b) * 128'(im)) >> (2 * FRAC_BITS);
    neg = 1'b0;
    if (inner < 0) begin
      if (term <= 128'(p_a)) r = 128'(p_a) - term;
      else begin
        r = term - 128'(p_a);
        neg = 1'b1;
      end
    end else begin
      r = term + 128'(p_a);
    end
    pt.tv = clamp_sm(neg, r, sat);
    // slope: zero root takes the quotient as zero
    q = 0;
    if (s != 0) begin
      qm = (dm << FRAC_BITS) / s;
      q = d < 0 ? -signed'(qm) : signed'(qm);
    end
    p = rho + q;
    pm = p < 0 ? -p : p;
    prod = (128'(p_b) * 128'(pm)) >> FRAC_BITS;
    pt.sl = clamp_sm(p < 0, prod, sat);
    // curvature: single exact division, zero root gives zero
    num = (128'(p_b) * 128'(sg2)) << FRAC_BITS;
    den = 128'(s * s) * 128'(s);
    quo = den == 0 ? 128'd0 : num / den;
    pt.cv = clamp_sm(1'b0, quo, sat);
    pt.convex = ~pt.cv[31];
    pt.sat = sat;
    return pt;
  endfunction

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // draw an idle gap: mostly none or short, a few long
  function automatic int draw_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < long_gap_pct / 2) return $urandom_range(40, 12);
    if (roll < 35) return $urandom_range(3, 1);
    return 0;
  endfunction

  // config write: setup then access cycle; predictor copy follows
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_LEVEL_A: p_a = value[22:0];
      REG_SLOPE_B: p_b = value[22:0];
      REG_SKEW_RHO: p_rho = value[20:0];
      REG_SHIFT_M: p_m = value[23:0];
      REG_SIGMA: p_sigma = value[22:0];
      default: ;
    endcase
  endtask

  task automatic load_params(input logic [22:0] a, input logic [22:0] b,
                             input logic [20:0] rho, input logic [23:0] m,
                             input logic [22:0] sigma);
    write_reg(REG_LEVEL_A, 32'(a));
    write_reg(REG_SLOPE_B, 32'(b));
    write_reg(REG_SKEW_RHO, 32'(rho));
    write_reg(REG_SHIFT_M, 32'(m));
    write_reg(REG_SIGMA, 32'(sigma));
  endtask

  // push one strike through the handshake, with an optional lead gap
  task automatic send_strike(input logic [23:0] strike);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pending_points.push_back(evaluate_smile(strike));
    in_valid <= 1'b1;
    in_strike_offset <= strike;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    strikes_sent++;
  endtask

  // drop valid after the last transfer, then wait for every point back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (CORE_LATENCY + 4) @(posedge clk);
  endtask

  // random strike, biased toward the shift so the root stays small at times
  function automatic logic [23:0] random_strike();
    int roll;
    roll = $urandom_range(9);
    if (roll == 0) return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
    if (roll < 3) return p_m + 24'($urandom_range(64)) - 24'd32;
    return 24'($urandom());
  endfunction

  // directed strikes; expected given only where it follows at once
  typedef struct {
    logic [23:0]  strike;
    logic         known;
    smile_point_t want;
  } strike_row_t;

  strike_row_t strike_table[$];

  // result side: random backpressure and compare against the oldest point
  always @(posedge clk) begin
    smile_point_t exp_pt;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_points.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result transfer tv=%h", out_total_variance);
        end else begin
          exp_pt = pending_points.pop_front();
          points_checked++;
          if (out_total_variance !== exp_pt.tv || out_slope !== exp_pt.sl ||
              out_curvature !== exp_pt.cv || out_convex_flag !== exp_pt.convex ||
              out_saturated !== exp_pt.sat) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: exp tv=%h sl=%h cv=%h cx=%b sat=%b",
                        " got tv=%h sl=%h cv=%h cx=%b sat=%b"},
                       exp_pt.tv, exp_pt.sl, exp_pt.cv, exp_pt.convex, exp_pt.sat,
                       out_total_variance, out_slope, out_curvature, out_convex_flag,
                       out_saturated);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= 30 - long_gap_pct) ? 1'b1 : 1'b0;
    end
  end

  // watchdog: cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d points pending", pending_points.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    strike_row_t row;
    smile_point_t zero_pt;
    logic [31:0] rd;
    logic [23:0] corner_strikes [8];
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    in_strike_offset = '0;
    mismatches = 0;
    strikes_sent = 0;
    points_checked = 0;
    idle_cycles = 0;
    long_gap_pct = 0;
    p_a = 23'd0;
    p_b = 23'd105;
    p_rho = 21'd0;
    p_m = 24'd0;
    p_sigma = 23'd1048576;
    corner_strikes = '{24'h7FFFFF, 24'h800000, 24'h000001, 24'hFFFFFF, 24'h100000,
                       24'hF00000, 24'h555555, 24'hAAAAAA};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults, d = 0: s = sigma = 1.0, tv = b, slope 0, curvature b
    row.strike = 24'd0;
    row.known = 1'b1;
    row.want = '{32'd105, 32'd0, 32'd105, 1'b1, 1'b0};
    strike_table.push_back(row);
    row.known = 1'b0;
    foreach (corner_strikes[i]) begin
      row.strike = corner_strikes[i];
      strike_table.push_back(row);
    end
    foreach (strike_table[i]) begin
      if (strike_table[i].known)
        pending_points.push_back(strike_table[i].want);
      else
        pending_points.push_back(evaluate_smile(strike_table[i].strike));
      in_valid <= 1'b1;
      in_strike_offset <= strike_table[i].strike;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      strikes_sent++;
    end
    drain_results();

    // readback of a register after a write
    write_reg(REG_LEVEL_A, 32'h0012_3456);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {REG_LEVEL_A, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd[22:0] !== 23'h123456) begin
      mismatches++;
      $display("readback of level a: exp %h got %h", 23'h123456, rd[22:0]);
    end

    // zero root: sigma = 0 and k = m, every quotient by s is zero
    load_params(23'd0, 23'h500000, 21'd1038090, 24'h123456, 23'd0);
    zero_pt.tv = 32'd0;
    zero_pt.sl = 32'd5190450; // b*rho >> 20, with b = 5.0
    zero_pt.cv = 32'd0;
    zero_pt.convex = 1'b1;
    zero_pt.sat = 1'b0;
    pending_points.push_back(zero_pt);
    in_valid <= 1'b1;
    in_strike_offset <= 24'h123456;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    strikes_sent++;
    send_strike(24'h123457);
    send_strike(24'h800000);
    drain_results();

    // extremes of every register, including out-of-range patterns
    load_params(23'h7FFFFF, 23'h7FFFFF, 21'h100000, 24'h7FFFFF, 23'd105);
    send_strike(24'h800000);
    send_strike(24'h7FFFFF);
    send_strike(24'h7FFF00);
    drain_results();
    load_params(23'h7FFFFF, 23'h7FFFFF, 21'h0FFFFF, 24'h800000, 23'h7FFFFF);
    send_strike(24'h7FFFFF);
    send_strike(24'h800000);
    drain_results();
    load_params(23'd0, 23'd105, 21'h1FFFFF, 24'h000000, 23'd1);
    send_strike(24'h000000);
    send_strike(24'h000001);
    send_strike(24'hFFFFFF);
    drain_results();

    // random phases: parameters redrawn between phases, pressure varied
    for (int ph = 0; ph < 10; ph++) begin
      long_gap_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1 ? 10 : 25);
      case (ph % 4)
        0: load_params(23'($urandom_range(2097152)), 23'($urandom_range(5242880, 105)),
                       21'($urandom_range(2076180) - 1038090), 24'($urandom()),
                       23'($urandom_range(8388607, 105)));
        1: load_params(23'($urandom()), 23'($urandom()), 21'($urandom()),
                       24'($urandom()), 23'($urandom()));
        2: load_params(23'($urandom_range(1048576)), 23'($urandom_range(2000, 105)),
                       21'($urandom_range(2076180) - 1038090),
                       24'($urandom_range(2097152) - 1048576), 23'($urandom_range(300, 0)));
        default: load_params(23'h7FFFFF, 23'd5242880, 21'(-1038090), 24'h800000,
                             23'd105);
      endcase
      for (int n = 0; n < RANDOM_STRIKES / 10; n++)
        send_strike(random_strike());
      drain_results();
    end

    repeat (CORE_LATENCY + 8) @(posedge clk);
    $display("sent %0d strikes over directed and ten random parameter phases", strikes_sent);
    $display("checked %0d smile points, %0d left pending", points_checked,
             pending_points.size());
    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/svice_pkg.sv
rtl/svice_sqrt_cell.sv
rtl/svice_div_cell.sv
rtl/svi_curve_evaluate_core.sv
bench/tb_svi_curve_evaluate_core.sv
